[rtl/core/tpc_pkg.sv]
// shared constants and types for the triangle perimeter check pipeline
package tpc_pkg;

    // coordinate and fixed-point format
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    // squared distance: two squares of a COORD_BITS magnitude, padded to an even width
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int D2_BITS    = 2 * COORD_BITS + 2;

    // root: one digit per bit pair of the scaled radicand
    localparam int ROOT_BITS  = COORD_BITS + FRAC_BITS + 1;
    localparam int RAD_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 3;

    // sum of two sides
    localparam int PAIR_BITS  = ROOT_BITS + 1;

    // result field widths
    localparam int SIDE_W     = 25;
    localparam int PERIM_W    = 27;

    // stage control: advance enable and the word valid bit
    typedef struct packed {
        logic en;
        logic vld;
    } tpc_ctl_t;

endpackage

[rtl/core/triangle_perimeter_check_unit.sv]
// Triangle check: takes three signed 16-bit vertices per word and returns the three side
// lengths (floor, 8 fraction bits), a triangle flag from the strict inequalities and the
// perimeter (zero when the flag is low). One word enters per cycle; each word passes through
// 3 stages of differences, squares and sums, 25 stages of the square root (one root
// digit per stage, three lanes side by side) and 2 stages of inequality check and
// output register. The whole pipeline advances together; while the output word is
// held by m_ready low, s_ready is low and nothing moves.
module triangle_perimeter_check_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  s_ax,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  s_ay,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  s_bx,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  s_by,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  s_cx,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  s_cy,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_is_triangle,
    output logic [tpc_pkg::SIDE_W-1:0]             m_side_ab,
    output logic [tpc_pkg::SIDE_W-1:0]             m_side_ac,
    output logic [tpc_pkg::SIDE_W-1:0]             m_side_bc,
    output logic [tpc_pkg::PERIM_W-1:0]            m_perimeter
);
    import tpc_pkg::*;

    logic                 en;
    tpc_ctl_t             dist_ctl;
    tpc_ctl_t             chk_ctl;
    logic [D2_BITS-1:0]   d2_ab, d2_ac, d2_bc;
    logic                 dist_vld;
    logic [ROOT_BITS-1:0] root_ab, root_ac, root_bc;
    logic                 vld_root_reg [ROOT_BITS];

    // pipeline advances whenever the output word is free or being taken
    assign en       = !m_valid || m_ready;
    assign s_ready  = en;
    assign dist_ctl = '{en: en, vld: s_valid};

    tpc_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dist_ctl),
        .ax      (s_ax),
        .ay      (s_ay),
        .bx      (s_bx),
        .by      (s_by),
        .cx      (s_cx),
        .cy      (s_cy),
        .d2_ab   (d2_ab),
        .d2_ac   (d2_ac),
        .d2_bc   (d2_bc),
        .vld     (dist_vld)
    );

    // three root lanes on the scaled squared distances
    tpc_root u_root_ab (
        .aclk (aclk),
        .en   (en),
        .rad  (RAD_BITS'(d2_ab) << (2 * FRAC_BITS)),
        .root (root_ab)
    );

    tpc_root u_root_ac (
        .aclk (aclk),
        .en   (en),
        .rad  (RAD_BITS'(d2_ac) << (2 * FRAC_BITS)),
        .root (root_ac)
    );

    tpc_root u_root_bc (
        .aclk (aclk),
        .en   (en),
        .rad  (RAD_BITS'(d2_bc) << (2 * FRAC_BITS)),
        .root (root_bc)
    );

    // valid bits alongside the root stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ROOT_BITS; k++) begin
                vld_root_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_root_reg[0] <= dist_vld;
            for (int k = 1; k < ROOT_BITS; k++) begin
                vld_root_reg[k] <= vld_root_reg[k-1];
            end
        end
    end

    assign chk_ctl = '{en: en, vld: vld_root_reg[ROOT_BITS-1]};

    tpc_check u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (chk_ctl),
        .ab          (root_ab),
        .ac          (root_ac),
        .bc          (root_bc),
        .out_valid   (m_valid),
        .is_triangle (m_is_triangle),
        .side_ab     (m_side_ab),
        .side_ac     (m_side_ac),
        .side_bc     (m_side_bc),
        .perimeter   (m_perimeter)
    );

    // a held output word stalls the input side
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output word is held");

    // no triangle means zero perimeter
    a_perim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_triangle |-> m_perimeter == '0)
        else $error("nonzero perimeter without triangle");

    // a triangle has no zero-length side
    a_tri_sides: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_triangle |->
            (m_side_ab != '0) && (m_side_ac != '0) && (m_side_bc != '0))
        else $error("triangle flagged with a zero side");

endmodule

[rtl/core/tpc_dist.sv]
// squared side lengths: abs differences, squares and sums over three register stages
module tpc_dist (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tpc_pkg::tpc_ctl_t                      ctl,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  ax,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  ay,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  bx,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  by,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  cx,
    input  logic signed [tpc_pkg::COORD_BITS-1:0]  cy,
    output logic [tpc_pkg::D2_BITS-1:0]            d2_ab,
    output logic [tpc_pkg::D2_BITS-1:0]            d2_ac,
    output logic [tpc_pkg::D2_BITS-1:0]            d2_bc,
    output logic                                   vld
);
    import tpc_pkg::*;

    // magnitude of p - q, which always fits COORD_BITS unsigned
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] q
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] nd;
        d  = {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
        nd = ~d + 1'b1;
        return d[COORD_BITS] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0] dif_reg [6];
    logic [SQ_BITS-1:0]    sq_reg  [6];
    logic [D2_BITS-1:0]    d2_reg  [3];
    logic [2:0]            vld_reg;

    // stage 1: coordinate differences, x then y per side
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            dif_reg[0] <= abs_diff(ax, bx);
            dif_reg[1] <= abs_diff(ay, by);
            dif_reg[2] <= abs_diff(ax, cx);
            dif_reg[3] <= abs_diff(ay, cy);
            dif_reg[4] <= abs_diff(bx, cx);
            dif_reg[5] <= abs_diff(by, cy);
        end
    end

    // stage 2: squares
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            for (int k = 0; k < 6; k++) begin
                sq_reg[k] <= dif_reg[k] * dif_reg[k];
            end
        end
    end

    // stage 3: squared distances
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            for (int k = 0; k < 3; k++) begin
                d2_reg[k] <= D2_BITS'(sq_reg[2*k]) + D2_BITS'(sq_reg[2*k+1]);
            end
        end
    end

    // valid bits follow the words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl.en) begin
            vld_reg <= {vld_reg[1:0], ctl.vld};
        end
    end

    assign d2_ab = d2_reg[0];
    assign d2_ac = d2_reg[1];
    assign d2_bc = d2_reg[2];
    assign vld   = vld_reg[2];

endmodule

[rtl/core/tpc_root_step.sv]
// one registered digit step of the restoring square root
module tpc_root_step (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [tpc_pkg::REM_BITS-1:0]    rem_in,
    input  logic [tpc_pkg::ROOT_BITS-1:0]   root_in,
    input  logic [tpc_pkg::RAD_BITS-1:0]    rad_in,
    output logic [tpc_pkg::REM_BITS-1:0]    rem_out,
    output logic [tpc_pkg::ROOT_BITS-1:0]   root_out,
    output logic [tpc_pkg::RAD_BITS-1:0]    rad_out
);
    import tpc_pkg::*;

    logic [REM_BITS-1:0]  rem_sh;
    logic [REM_BITS-1:0]  trial;
    logic                 fits;
    logic [REM_BITS-1:0]  rem_next;
    logic [ROOT_BITS-1:0] root_next;
    logic [RAD_BITS-1:0]  rad_next;
    logic [REM_BITS-1:0]  rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [RAD_BITS-1:0]  rad_reg;

    // bring down the next bit pair and try root*4+1
    always_comb begin
        rem_sh    = {rem_in[REM_BITS-3:0], rad_in[RAD_BITS-1:RAD_BITS-2]};
        trial     = REM_BITS'({root_in, 2'b01});
        fits      = (rem_sh >= trial);
        rem_next  = fits ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[ROOT_BITS-2:0], fits};
        rad_next  = {rad_in[RAD_BITS-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

[rtl/core/tpc_root.sv]
// pipelined floor square root, one digit step per register stage
module tpc_root (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [tpc_pkg::RAD_BITS-1:0]    rad,
    output logic [tpc_pkg::ROOT_BITS-1:0]   root
);
    import tpc_pkg::*;

    logic [REM_BITS-1:0]  rem_w  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] root_w [ROOT_BITS+1];
    logic [RAD_BITS-1:0]  rad_w  [ROOT_BITS+1];

    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign rad_w[0]  = rad;

    // chain of digit stages, most significant digit first
    for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
        tpc_root_step u_step (
            .aclk     (aclk),
            .en       (en),
            .rem_in   (rem_w[i]),
            .root_in  (root_w[i]),
            .rad_in   (rad_w[i]),
            .rem_out  (rem_w[i+1]),
            .root_out (root_w[i+1]),
            .rad_out  (rad_w[i+1])
        );
    end

    assign root = root_w[ROOT_BITS];

endmodule

[rtl/core/tpc_check.sv]
// triangle inequality, perimeter and the output register
module tpc_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tpc_pkg::tpc_ctl_t               ctl,
    input  logic [tpc_pkg::ROOT_BITS-1:0]   ab,
    input  logic [tpc_pkg::ROOT_BITS-1:0]   ac,
    input  logic [tpc_pkg::ROOT_BITS-1:0]   bc,
    output logic                            out_valid,
    output logic                            is_triangle,
    output logic [tpc_pkg::SIDE_W-1:0]      side_ab,
    output logic [tpc_pkg::SIDE_W-1:0]      side_ac,
    output logic [tpc_pkg::SIDE_W-1:0]      side_bc,
    output logic [tpc_pkg::PERIM_W-1:0]     perimeter
);
    import tpc_pkg::*;

    logic [ROOT_BITS-1:0] ab_reg, ac_reg, bc_reg;
    logic [PAIR_BITS-1:0] s_abac_reg, s_abbc_reg, s_acbc_reg;
    logic                 vld1_reg;

    logic                 ok;
    logic [PERIM_W-1:0]   perim_next;

    logic                 m_valid_reg;
    logic                 tri_reg;
    logic [SIDE_W-1:0]    side_ab_reg, side_ac_reg, side_bc_reg;
    logic [PERIM_W-1:0]   perim_reg;

    // stage 1: pairwise sums
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            ab_reg     <= ab;
            ac_reg     <= ac;
            bc_reg     <= bc;
            s_abac_reg <= PAIR_BITS'(ab) + PAIR_BITS'(ac);
            s_abbc_reg <= PAIR_BITS'(ab) + PAIR_BITS'(bc);
            s_acbc_reg <= PAIR_BITS'(ac) + PAIR_BITS'(bc);
        end
    end

    // strict inequalities and perimeter
    always_comb begin
        ok = (s_abac_reg > PAIR_BITS'(bc_reg)) &&
             (s_abbc_reg > PAIR_BITS'(ac_reg)) &&
             (s_acbc_reg > PAIR_BITS'(ab_reg));
        perim_next = ok ? (PERIM_W'(s_abac_reg) + PERIM_W'(bc_reg)) : '0;
    end

    // stage 2: output word
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            tri_reg     <= ok;
            side_ab_reg <= SIDE_W'(ab_reg);
            side_ac_reg <= SIDE_W'(ac_reg);
            side_bc_reg <= SIDE_W'(bc_reg);
            perim_reg   <= perim_next;
        end
    end

    // valid bits for both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (ctl.en) begin
            vld1_reg    <= ctl.vld;
            m_valid_reg <= vld1_reg;
        end
    end

    assign out_valid   = m_valid_reg;
    assign is_triangle = tri_reg;
    assign side_ab     = side_ab_reg;
    assign side_ac     = side_ac_reg;
    assign side_bc     = side_bc_reg;
    assign perimeter   = perim_reg;

endmodule

[tb/tb.sv]
// testbench for the triangle perimeter check unit: random and directed vertex words
`timescale 1ns / 100ps

module tb;

    import tpc_pkg::*;

    // one expected result word
    typedef struct {
        bit                 flag;
        bit [SIDE_W-1:0]    ab;
        bit [SIDE_W-1:0]    ac;
        bit [SIDE_W-1:0]    bc;
        bit [PERIM_W-1:0]   perim;
    } triangle_word_t;

    // predicts each accepted vertex word and checks results in order
    class triangle_expectations;
        triangle_word_t pending_shapes[$];
        int             n_mismatch = 0;

        // one line per mismatch, printing capped so a broken block stays readable
        task report(string what, longint unsigned got, longint unsigned want);
            if (n_mismatch < 40)
                $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
            n_mismatch++;
        endtask

        // floor of the distance scaled by 2^FRAC_BITS, bit by bit from the top
        function longint unsigned scaled_length(longint x1, longint y1, longint x2, longint y2);
            longint unsigned dx, dy, rad, root, trial;
            dx = (x1 >= x2) ? x1 - x2 : x2 - x1;
            dy = (y1 >= y2) ? y1 - y2 : y2 - y1;
            rad = (dx * dx + dy * dy) << (2 * FRAC_BITS);
            root = 0;
            for (int i = ROOT_BITS; i >= 0; i--) begin
                trial = root | (64'd1 << i);
                if (trial * trial <= rad)
                    root = trial;
            end
            return root;
        endfunction

        // accepted input word: predict and queue
        function void note_vertices(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy);
            longint unsigned ab, ac, bc;
            triangle_word_t  w;
            ab = scaled_length(ax, ay, bx, by);
            ac = scaled_length(ax, ay, cx, cy);
            bc = scaled_length(bx, by, cx, cy);
            w.flag  = (ab + ac > bc) && (ab + bc > ac) && (ac + bc > ab);
            w.ab    = ab[SIDE_W-1:0];
            w.ac    = ac[SIDE_W-1:0];
            w.bc    = bc[SIDE_W-1:0];
            w.perim = w.flag ? PERIM_W'(ab + ac + bc) : '0;
            pending_shapes.push_back(w);
        endfunction

        // accepted result word: compare with the oldest prediction
        task check_word(logic flag, logic [SIDE_W-1:0] ab, logic [SIDE_W-1:0] ac,
                        logic [SIDE_W-1:0] bc, logic [PERIM_W-1:0] perim);
            triangle_word_t w;
            if (pending_shapes.size() == 0) begin
                report("result word with nothing pending", 0, 0);
            end else begin
                w = pending_shapes.pop_front();
                if (flag !== w.flag)   report("is_triangle", flag, w.flag);
                if (ab !== w.ab)       report("side_ab", ab, w.ab);
                if (ac !== w.ac)       report("side_ac", ac, w.ac);
                if (bc !== w.bc)       report("side_bc", bc, w.bc);
                if (perim !== w.perim) report("perimeter", perim, w.perim);
            end
        endtask
    endclass

    logic                          aclk = 0;
    logic                          aresetn = 0;
    logic                          s_valid = 0;
    logic                          s_ready;
    logic signed [COORD_BITS-1:0]  s_ax = 0, s_ay = 0, s_bx = 0, s_by = 0, s_cx = 0, s_cy = 0;
    logic                          m_valid;
    logic                          m_ready = 0;
    logic                          m_is_triangle;
    logic [SIDE_W-1:0]             m_side_ab, m_side_ac, m_side_bc;
    logic [PERIM_W-1:0]            m_perimeter;

    triangle_expectations shapes = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    triangle_perimeter_check_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ax          (s_ax),
        .s_ay          (s_ay),
        .s_bx          (s_bx),
        .s_by          (s_by),
        .s_cx          (s_cx),
        .s_cy          (s_cy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_triangle (m_is_triangle),
        .m_side_ab     (m_side_ab),
        .m_side_ac     (m_side_ac),
        .m_side_bc     (m_side_bc),
        .m_perimeter   (m_perimeter)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard limit on the run
    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // handshake monitor, sampled at the edge before any drive updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                shapes.note_vertices(s_ax, s_ay, s_bx, s_by, s_cx, s_cy);
            if (m_valid && m_ready)
                shapes.check_word(m_is_triangle, m_side_ab, m_side_ac, m_side_bc, m_perimeter);
        end
    end

    // result side back-pressure
    initial begin : rx_stall
        int stall_left;
        stall_left = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap(rx_idle_pct);
            end
            @(posedge aclk);
        end
    end

    // present one vertex word and hold it until accepted
    task automatic send_vertices(int ax, int ay, int bx, int by, int cx, int cy);
        s_valid <= 1'b1;
        s_ax <= ax[COORD_BITS-1:0];
        s_ay <= ay[COORD_BITS-1:0];
        s_bx <= bx[COORD_BITS-1:0];
        s_by <= by[COORD_BITS-1:0];
        s_cx <= cx[COORD_BITS-1:0];
        s_cy <= cy[COORD_BITS-1:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender idle after an accepted word
    task automatic sender_gap();
        int gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // coordinate from a style: full range, near zero, or the extreme values
    function automatic int pick_coord(int style);
        int corner[5] = '{-32768, -1, 0, 1, 32767};
        case (style)
            0:       return int'($signed($urandom_range(65535, 0) - 32768));
            1:       return $urandom_range(16, 0) - 8;
            default: return corner[$urandom_range(4, 0)];
        endcase
    endfunction

    // one random word: mostly arbitrary, some collinear or coincident
    task automatic send_random_word();
        int kind, ax, ay, dx, dy, k;
        kind = $urandom_range(9, 0);
        if (kind < 2) begin
            // collinear points, including repeated vertices
            ax = $urandom_range(2000, 0) - 1000;
            ay = $urandom_range(2000, 0) - 1000;
            dx = $urandom_range(200, 0) - 100;
            dy = $urandom_range(200, 0) - 100;
            k  = $urandom_range(6, 0) - 3;
            send_vertices(ax, ay, ax + dx, ay + dy, ax + k * dx, ay + k * dy);
        end else begin
            k = (kind < 7) ? 0 : (kind < 9) ? 1 : 2;
            send_vertices(pick_coord(k), pick_coord(k), pick_coord(k),
                          pick_coord(k), pick_coord(k), pick_coord(k));
        end
        sender_gap();
    endtask

    // stimulus
    initial begin : stimulus
        int waited;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words, back to back
        send_vertices(0, 0, 0, 0, 0, 0);
        send_vertices(-32768, -32768, 32767, 32767, -32768, 32767);
        send_vertices(32767, 32767, -32768, -32768, 32767, -32768);
        send_vertices(-32768, -32768, 32767, 32767, 0, 0);
        send_vertices(0, 0, 3, 0, 0, 4);
        send_vertices(0, 0, 1, 0, 2, 0);
        send_vertices(5, 5, 5, 5, 9, -2);
        send_vertices(-7, 3, 11, -4, -7, 3);
        send_vertices(1, 1, 1, 1, 1, 1);
        send_vertices(-32768, 0, 32767, 0, 0, 1);
        send_vertices(0, 0, 1, 0, 0, 1);
        send_vertices(0, 0, 2, 0, 1, 1);
        send_vertices(-1, -1, -1, -1, 0, 0);
        send_vertices(32767, 0, -32768, 0, 0, 32767);
        send_vertices(0, -32768, 0, 32767, 32767, 0);
        send_vertices(-100, 0, 100, 0, 0, 173);
        send_vertices(-21846, 21845, -21846, -21846, 21845, 0);
        send_vertices(-1, 0, 0, -1, 1, 1);
        send_vertices(32767, 32767, 32767, 32767, 32767, 32767);
        send_vertices(-32768, -32768, -32768, -32768, -32768, -32768);
        send_vertices(-5, -5, 10, 10, 25, 25);

        // random words over phases of different idling
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                1: begin tx_idle_pct = 30; rx_idle_pct = 30; end
                2: begin tx_idle_pct = 70; rx_idle_pct = 10; end
                default: begin tx_idle_pct = 10; rx_idle_pct = 70; end
            endcase
            repeat (225) send_random_word();
        end
        s_valid <= 1'b0;

        // drain the pipeline, then some margin
        waited = 0;
        while (shapes.pending_shapes.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (shapes.pending_shapes.size() != 0)
            shapes.report("results never returned", 0, shapes.pending_shapes.size());

        if (shapes.n_mismatch == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
